// File: hdl/lir_pkg.sv
// Package for the linear interpolation resampler: block geometry, field widths,
// item structs and the interpolation table entry type. No dependencies.
package lir_pkg;

  // Block geometry
  localparam int IN_PER_BLOCK  = 2100;
  localparam int OUT_PER_BLOCK = 2048;
  localparam int FRAC_BITS     = 16;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int OUT_W    = 20;

  // Derived widths
  localparam int ADDR_W = $clog2(OUT_PER_BLOCK);       // table address
  localparam int IDX_W  = $clog2(OUT_PER_BLOCK + 1);   // output index, holds the count too
  localparam int POS_W  = $clog2(IN_PER_BLOCK + 1);    // block position
  localparam int BASE_W = $clog2(IN_PER_BLOCK);        // integer part of a table position

  // Table fill steps: position advances by IN/OUT input samples per output
  localparam int STEP_BASE = IN_PER_BLOCK / OUT_PER_BLOCK;
  localparam int STEP_REM  = IN_PER_BLOCK % OUT_PER_BLOCK;

  // Interpolation arithmetic
  localparam int PROD_W    = SAMPLE_W + FRAC_BITS + 2;
  localparam int OUT_SHIFT = FRAC_BITS - 8;
  localparam int ROUND_ADD = (OUT_SHIFT > 0) ? (1 << (OUT_SHIFT - 1)) : 0;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_i;
    logic signed [OUT_W-1:0] out_q;
    logic                    block_last;
  } out_item_t;

  typedef struct packed {
    logic [BASE_W-1:0]    base;
    logic [FRAC_BITS-1:0] frac;
  } tbl_entry_t;

endpackage

// File: hdl/lir_tbl.sv
// Interpolation position table: fills a synchronous memory after reset with
// base and fraction for every output of a block, then serves one read a cycle.
// Depends on lir_pkg.
module lir_tbl import lir_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output tbl_entry_t        rd_data_o,
  output logic              ready_o
);

  typedef enum logic [1:0] {
    StFill,
    StWarm,
    StRun
  } tbl_state_e;

  tbl_state_e        state_q;
  logic [ADDR_W-1:0] fill_cnt_q;
  logic [BASE_W-1:0] acc_base_q;
  logic [ADDR_W-1:0] acc_rem_q;
  logic              ready_q;

  tbl_entry_t tbl_mem [OUT_PER_BLOCK];
  tbl_entry_t rd_data_q;
  tbl_entry_t wr_data;
  logic       wr_en;

  logic [ADDR_W:0]           rem_sum;
  logic                      rem_wrap;
  logic [ADDR_W+FRAC_BITS-1:0] rem_wide;

  assign rem_sum  = (ADDR_W+1)'(acc_rem_q) + (ADDR_W+1)'(STEP_REM);
  assign rem_wrap = rem_sum >= (ADDR_W+1)'(OUT_PER_BLOCK);
  assign rem_wide = {acc_rem_q, {FRAC_BITS{1'b0}}};

  assign wr_en        = state_q == StFill;
  assign wr_data.base = acc_base_q;
  assign wr_data.frac = FRAC_BITS'(rem_wide / OUT_PER_BLOCK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StFill;
      fill_cnt_q <= '0;
      acc_base_q <= '0;
      acc_rem_q  <= '0;
      ready_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StFill: begin
          // advance the position by IN/OUT, carry the remainder into the base
          if (rem_wrap) begin
            acc_rem_q  <= ADDR_W'(rem_sum - (ADDR_W+1)'(OUT_PER_BLOCK));
            acc_base_q <= BASE_W'(acc_base_q + BASE_W'(STEP_BASE) + 1'b1);
          end else begin
            acc_rem_q  <= ADDR_W'(rem_sum);
            acc_base_q <= BASE_W'(acc_base_q + BASE_W'(STEP_BASE));
          end
          if (fill_cnt_q == ADDR_W'(OUT_PER_BLOCK - 1)) begin
            state_q <= StWarm;
          end else begin
            fill_cnt_q <= fill_cnt_q + 1'b1;
          end
        end
        StWarm: begin
          // first read of the running address lands this cycle
          state_q <= StRun;
          ready_q <= 1'b1;
        end
        StRun: begin
          state_q <= StRun;
        end
        default: begin
          state_q <= StFill;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[fill_cnt_q] <= wr_data;
    end
    rd_data_q <= tbl_mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ready_q;

  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |=> ready_q)
    else $error("table ready dropped after fill");

  a_fill_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StFill) |=> $stable(fill_cnt_q))
    else $error("fill counter moved outside the fill sweep");

  a_ready_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q == (state_q == StRun))
    else $error("table ready out of step with the run state");

endmodule

// File: hdl/lir_mac.sv
// Two-tap weighted sum for one channel: registered products, then sum and
// round to 8 fraction bits. Depends on lir_pkg.
module lir_mac import lir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] a_i,
  input  logic signed [SAMPLE_W-1:0] c_i,
  input  logic [FRAC_BITS-1:0]       frac_i,
  input  logic [FRAC_BITS:0]         omf_i,
  output logic signed [OUT_W-1:0]    res_o
);

  logic signed [PROD_W-1:0] pa_d, pa_q;
  logic signed [PROD_W-1:0] pc_d, pc_q;
  logic signed [PROD_W:0]   sum;
  logic signed [PROD_W:0]   shifted;

  assign pa_d = PROD_W'(a_i) * PROD_W'($signed({1'b0, omf_i}));
  assign pc_d = PROD_W'(c_i) * PROD_W'($signed({1'b0, frac_i}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pc_q <= pc_d;
    end
  end

  // floor((s + half) / 2^shift) rounds to nearest, ties upward
  assign sum     = (PROD_W+1)'(pa_q) + (PROD_W+1)'(pc_q) + (PROD_W+1)'(ROUND_ADD);
  assign shifted = sum >>> OUT_SHIFT;
  assign res_o   = shifted[OUT_W-1:0];

endmodule

// File: hdl/linear_interp_resampler_core.sv
// Linear interpolation resampler top level: block position tracking, table
// lookup, interpolation pipeline and result queue. Depends on lir_pkg,
// lir_tbl and lir_mac.
//
// Usage: complex 12-bit samples enter on the in channel (in_valid_i,
// in_stall_o, in_item_i); interpolated samples leave on the out channel
// (out_valid_o, out_stall_i, out_item_o), block_last marking the final
// output of each resampling block. Every IN_PER_BLOCK input items yield
// OUT_PER_BLOCK result items; the first block takes one extra item.
// Throughput: one input item per cycle, sustained, as long as the receiver
// keeps up. The table read for the next output is issued from the next value
// of the output index, so the single read port never costs a bubble.
// Path: a result item reaches the out channel through the operand stage, the
// product stage, and then the sum and round into the result queue.
// Reset: the position table is filled in a sweep over all OUT_PER_BLOCK entries,
// then the read port is primed; in_stall_o stays high until it is done.
// Receiver stall: results collect in a FIFO_DEPTH entry queue; the input
// stalls only once the results queued or in flight fill it, so a held result
// does not block input items that are still being taken.
module linear_interp_resampler_core import lir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Block state
  logic signed [SAMPLE_W-1:0] prev_i_q, prev_q_q;
  logic [POS_W-1:0]           pos_q;
  logic [IDX_W-1:0]           oi_q, oi_d, oi_nxt;

  // Table port
  tbl_entry_t tbl_entry;
  logic       tbl_ready;

  // Handshake and decision
  logic accept;
  logic due;
  logic push;
  logic take;

  // Stage 1: operands
  logic                       s1_vld_q;
  logic signed [SAMPLE_W-1:0] s1_a_i_q, s1_a_q_q, s1_c_i_q, s1_c_q_q;
  logic [FRAC_BITS-1:0]       s1_frac_q;
  logic [FRAC_BITS:0]         s1_omf_q;
  logic                       s1_last_q;

  // Stage 2: products (inside lir_mac)
  logic                    s2_vld_q;
  logic                    s2_last_q;
  logic signed [OUT_W-1:0] res_i, res_q;

  // Result queue
  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] fifo_cnt_q;
  logic [FIFO_CW-1:0] res_cnt_q;  // results in the pipe plus results queued
  out_item_t          push_item;

  lir_tbl u_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (oi_d[ADDR_W-1:0]),
    .rd_data_o (tbl_entry),
    .ready_o   (tbl_ready)
  );

  assign in_stall_o = !tbl_ready || (res_cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // An entry is due once its right-hand sample, base + 1, is the current one.
  // IN_PER_BLOCK >= OUT_PER_BLOCK, so no two entries fall due on one sample.
  assign due    = (oi_q < IDX_W'(OUT_PER_BLOCK)) && (POS_W'(tbl_entry.base) < pos_q);
  assign oi_nxt = oi_q + 1'b1;

  always_comb begin
    oi_d = oi_q;
    if (accept) begin
      if (pos_q >= POS_W'(IN_PER_BLOCK)) begin
        oi_d = '0;
      end else if (due) begin
        oi_d = oi_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_i_q <= '0;
      prev_q_q <= '0;
      pos_q    <= '0;
      oi_q     <= '0;
    end else begin
      oi_q <= oi_d;
      if (accept) begin
        prev_i_q <= in_item_i.sample_i;
        prev_q_q <= in_item_i.sample_q;
        // the last sample of a block becomes sample zero of the next
        if (pos_q >= POS_W'(IN_PER_BLOCK)) begin
          pos_q <= POS_W'(1);
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // Stage 1: capture the two taps and the weights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept && due;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && due) begin
      s1_a_i_q  <= prev_i_q;
      s1_a_q_q  <= prev_q_q;
      s1_c_i_q  <= in_item_i.sample_i;
      s1_c_q_q  <= in_item_i.sample_q;
      s1_frac_q <= tbl_entry.frac;
      s1_omf_q  <= (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, tbl_entry.frac};
      s1_last_q <= oi_nxt == IDX_W'(OUT_PER_BLOCK);
    end
    if (s1_vld_q) begin
      s2_last_q <= s1_last_q;
    end
  end

  lir_mac u_mac_i (
    .clk_i  (clk_i),
    .en_i   (s1_vld_q),
    .a_i    (s1_a_i_q),
    .c_i    (s1_c_i_q),
    .frac_i (s1_frac_q),
    .omf_i  (s1_omf_q),
    .res_o  (res_i)
  );

  lir_mac u_mac_q (
    .clk_i  (clk_i),
    .en_i   (s1_vld_q),
    .a_i    (s1_a_q_q),
    .c_i    (s1_c_q_q),
    .frac_i (s1_frac_q),
    .omf_i  (s1_omf_q),
    .res_o  (res_q)
  );

  // Result queue: push from the sum stage, pop on the out handshake
  assign push                 = s2_vld_q;
  assign take                 = out_valid_o && !out_stall_i;
  assign push_item.out_i      = res_i;
  assign push_item.out_q      = res_q;
  assign push_item.block_last = s2_last_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (take) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(push) - FIFO_CW'(take);
      // hold a credit for every result from acceptance until it leaves
      res_cnt_q  <= res_cnt_q + FIFO_CW'(accept && due) - FIFO_CW'(take);
    end
  end

  assign out_valid_o = fifo_cnt_q != '0;
  assign out_item_o  = fifo_mem[rd_ptr_q];

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("result credits exceed queue depth");

  a_queue_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= res_cnt_q)
    else $error("queued results exceed outstanding credits");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < FIFO_CW'(FIFO_DEPTH)) || take)
    else $error("push into a full result queue");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pos_q != '0)
    else $error("block position back at zero after an item");

endmodule

// File: bench/tb_linear_interp_resampler_core.sv
// Testbench for linear_interp_resampler_core: random and directed I/Q sample
// streams checked against an in-bench interpolation predictor. Depends on
// lir_pkg and the core RTL only.
module tb_linear_interp_resampler_core;
  import lir_pkg::*;

  // Cycles without a handshake on either channel before the run is declared
  // hung. Covers the table fill sweep after reset several times over.
  localparam int HANG_LIMIT = 10000;
  localparam int IDLE_PCT   = 17;
  localparam int RANDOM_ITEMS = 850;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = -(1 <<< (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] S_MAX = (1 <<< (SAMPLE_W - 1)) - 1;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Random idling on both sides; cleared for a long burst in the random test.
  bit idle_en = 1'b1;

  // Predictor state: position table and the running block position.
  int base_tab[OUT_PER_BLOCK];
  int frac_tab[OUT_PER_BLOCK];
  int prev_i, prev_q;
  int blk_pos, tab_idx;
  int block_ends;

  out_item_t pending_outputs[$];
  int        mismatch_count;
  int        quiet_cycles;

  linear_interp_resampler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Build the interpolation map: entry j sits at j*IN/OUT input samples,
  // integer part in base, remainder truncated to FRAC_BITS in frac.
  function automatic void fill_position_map();
    longint num;
    for (int j = 0; j < OUT_PER_BLOCK; j++) begin
      num = longint'(j) * IN_PER_BLOCK;
      base_tab[j] = int'(num / OUT_PER_BLOCK);
      frac_tab[j] = int'(((num % OUT_PER_BLOCK) << FRAC_BITS) / OUT_PER_BLOCK);
    end
  endfunction

  // a*(1-f) + c*f in Q.FRAC_BITS, rounded half up to 8 fraction bits.
  function automatic logic signed [OUT_W-1:0] lerp_round(int a, int c, int f);
    longint acc;
    longint half;
    half = (FRAC_BITS > 8) ? (longint'(1) << (FRAC_BITS - 9)) : 0;
    acc  = longint'(a) * ((longint'(1) << FRAC_BITS) - f) + longint'(c) * f;
    acc  = (acc + half) >>> (FRAC_BITS - 8);
    return OUT_W'(acc);
  endfunction

  // Advance the predictor by one accepted sample and queue any output it owes.
  function automatic void resample_step(in_item_t it);
    int        ci, cq, p;
    out_item_t r;
    ci = it.sample_i;
    cq = it.sample_q;
    p  = blk_pos;
    if (p >= 1 && tab_idx < OUT_PER_BLOCK && base_tab[tab_idx] + 1 <= p) begin
      r.out_i = lerp_round(prev_i, ci, frac_tab[tab_idx]);
      r.out_q = lerp_round(prev_q, cq, frac_tab[tab_idx]);
      tab_idx++;
      // Skip further entries due on this same sample: one output per step.
      while (tab_idx < OUT_PER_BLOCK && base_tab[tab_idx] + 1 <= p) tab_idx++;
      r.block_last = (tab_idx >= OUT_PER_BLOCK);
      if (r.block_last) block_ends++;
      pending_outputs.push_back(r);
    end
    prev_i = ci;
    prev_q = cq;
    // The last sample of a block becomes position zero of the next one.
    if (p >= IN_PER_BLOCK) begin
      blk_pos = 1;
      tab_idx = 0;
    end else begin
      blk_pos = p + 1;
    end
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshakes, check on output handshakes, and
  // watch for a hung block. Sampled at the edge, before any drive updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      resample_step(in_item_i);
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected item out_i %0d out_q %0d block_last %0d", $time,
                 out_item_o.out_i, out_item_o.out_q, out_item_o.block_last);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        report_field("out_i", want.out_i, out_item_o.out_i);
        report_field("out_q", want.out_q, out_item_o.out_q);
        report_field("block_last", want.block_last, out_item_o.block_last);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall at random while idling is enabled.
  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one item and hold it until accepted. Valid stays high on return so
  // back-to-back items go out without a bubble.
  task automatic send_sample(input in_item_t it);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every owed output has been checked.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly full-range values, with extremes and small values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return SAMPLE_W'($urandom);
    if (sel < 90) begin
      case ($urandom_range(3))
        0:       return S_MIN;
        1:       return S_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'($urandom_range(16) - 8);
  endfunction

  function automatic in_item_t random_sample();
    in_item_t it;
    it.sample_i = pick_value();
    it.sample_q = pick_value();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and sign patterns. The first item after reset takes
  // position zero and must produce nothing; equal extreme pairs hit the
  // output extremes regardless of the fraction.
  task automatic test_extremes();
    int vi[] = '{0, -2048, -2048, 2047, 2047, -2048, 2047, -2048, -1, 1, 0,
                 -1366, 1365, -2048, 0, 2047, 0, -1, 1, 2047};
    int vq[] = '{0, -2048, -2048, 2047, 2047, 2047, -2048, 2047, 1, -1, 0,
                 1365, -1366, 0, 2047, 0, -2048, -1, 1, -2048};
    in_item_t it;
    for (int k = 0; k < vi.size(); k++) begin
      it.sample_i = SAMPLE_W'(vi[k]);
      it.sample_q = SAMPLE_W'(vq[k]);
      send_sample(it);
    end
    drain_outputs();
  endtask

  // Random stream with random idling on both sides, except for one long
  // burst where both sides run flat out.
  task automatic test_random_samples();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = !(n >= 350 && n < 550);
      send_sample(random_sample());
    end
    idle_en = 1'b1;
    drain_outputs();
  endtask

  // Keep streaming across two block boundaries: the first block takes one
  // extra sample, later blocks exactly IN_PER_BLOCK, and the table restarts.
  task automatic test_block_wrap();
    while (block_ends < 2) send_sample(random_sample());
    repeat (40) send_sample(random_sample());
    drain_outputs();
  endtask

  initial begin
    fill_position_map();
    prev_i         = 0;
    prev_q         = 0;
    blk_pos        = 0;
    tab_idx        = 0;
    block_ends     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_random_samples();
    test_block_wrap();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: linear_interp_resampler_core.f
hdl/lir_pkg.sv
hdl/lir_tbl.sv
hdl/lir_mac.sv
hdl/linear_interp_resampler_core.sv
bench/tb_linear_interp_resampler_core.sv
